[hdl/curv_pkg.sv]
package curv_pkg;

    localparam int TAN_BITS = 30;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CALC_MUL  = 2'd0,
        CALC_DIV  = 2'd1,
        CALC_SQRT = 2'd2
    } t_calc_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_DEGEN = 2'd2
    } t_status;

    typedef struct packed {
        logic        start;
        t_calc_op    op;
        logic [63:0] a;
        logic [63:0] b;
    } t_calc_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_calc_rsp;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic [15:0] point_index;
        logic [31:0] curvature;
        logic        run_end;
        logic [31:0] mean_curvature;
        logic [31:0] max_curvature;
        logic [1:0]  status;
    } t_out_item;

endpackage

[hdl/curve_curvature_stream_top.sv]
// Polyline curvature, one point per input transfer.
// Points are worked one at a time on the shared bit-serial unit; a zero-length
// segment skips the curvature arithmetic, and the last point of a curve adds
// the end length and mean.
// A result is shown when the point's arithmetic finishes; the input
// is not ready from acceptance until all results of that point are taken.
// Reset: synchronous active low, clears the sequencer, running sums and config.
module curve_curvature_stream_top
    import curv_pkg::*;
#(
    parameter int MAX_POINTS = 65536,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [18:0] {
        S_IDLE  = 19'd1,
        S_PREP  = 19'd2,
        S_SQ    = 19'd4,
        S_RT    = 19'd8,
        S_TDIV  = 19'd16,
        S_SEG   = 19'd32,
        S_KSQ   = 19'd64,
        S_KRT   = 19'd128,
        S_KDIV  = 19'd256,
        S_MIDP  = 19'd512,
        S_KMUL0 = 19'd1024,
        S_KMUL1 = 19'd2048,
        S_ACC   = 19'd4096,
        S_EMA   = 19'd8192,
        S_EMB   = 19'd16384,
        S_UPD   = 19'd32768,
        S_FIN   = 19'd65536,
        S_MEAN  = 19'd131072,
        S_EMF   = 19'd262144
    } t_state;

    typedef enum logic [1:0] {
        M_SEG = 2'd0,
        M_MID = 2'd1,
        M_END = 2'd2
    } t_mode;

    t_state r_state;
    t_mode  r_mode;
    logic   r_wait;
    logic   r_closed;
    logic   r_last;
    logic [1:0] r_i;

    logic signed [31:0] r_p[3];
    logic signed [31:0] r_prev_p[3];
    logic signed [31:0] r_prev_t[3];
    logic signed [31:0] r_prev_m[3];
    logic signed [31:0] r_t[3];
    logic signed [31:0] r_mid[3];
    logic signed [32:0] r_d[3];
    logic [31:0] r_a[3];
    logic [1:0]  r_s;
    logic [63:0] r_sum;
    logic [31:0] r_ls;
    logic [34:0] r_L;
    logic [34:0] r_len;
    logic [31:0] r_k;
    logic [66:0] r_prod;
    logic [CW-1:0] r_count;
    logic [31:0] r_max;
    logic [63:0] r_wsum;
    logic [47:0] r_lsum;
    logic        r_degen;
    logic [31:0] r_last_k;
    t_out_item   r_out;

    t_calc_req calc_req;
    t_calc_rsp calc_rsp;

    logic [32:0] mag_d[3];
    logic [32:0] mag_max;
    logic [1:0]  s_c;
    logic [31:0] a_c[3];
    logic signed [32:0] kdiff[3];
    logic [31:0] kmag[3];
    logic signed [32:0] msum[3];
    logic signed [31:0] mid_c[3];
    logic [34:0] vl_c;
    logic [63:0] prod_sat;
    logic [64:0] wsum_add;
    logic [48:0] lsum_mid;
    logic [48:0] lsum_end;
    logic [1:0]  st_c;
    logic [31:0] mean_c;

    curv_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (calc_req),
        .o_rsp   (calc_rsp)
    );

    function automatic t_out_item mk_out(logic [15:0] idx, logic [31:0] k, logic e,
                                         logic [31:0] mn, logic [31:0] mx,
                                         logic [1:0] st);
        t_out_item o;
        o.point_index    = idx;
        o.curvature      = k;
        o.run_end        = e;
        o.mean_curvature = mn;
        o.max_curvature  = mx;
        o.status         = st;
        return o;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_d[i] = r_d[i][32] ? $unsigned(-r_d[i]) : $unsigned(r_d[i]);
            kdiff[i] = {r_t[i][31], r_t[i]} - {r_prev_t[i][31], r_prev_t[i]};
            kmag[i]  = kdiff[i][32] ? 32'($unsigned(-kdiff[i])) : 32'($unsigned(kdiff[i]));
            msum[i]  = {r_p[i][31], r_p[i]} + {r_prev_p[i][31], r_prev_p[i]};
            mid_c[i] = msum[i][32:1];
        end
        mag_max = mag_d[0];
        if (mag_d[1] > mag_max) mag_max = mag_d[1];
        if (mag_d[2] > mag_max) mag_max = mag_d[2];
        s_c = mag_max[32] ? 2'd2 : (mag_max[31] ? 2'd1 : 2'd0);
        for (int i = 0; i < 3; i++) begin
            a_c[i] = 32'(mag_d[i] >> s_c);
        end
        vl_c     = 35'(calc_rsp.res[31:0]) << r_s;
        prod_sat = (|r_prod[66:64]) ? '1 : r_prod[63:0];
        wsum_add = {1'b0, r_wsum} + {1'b0, prod_sat};
        lsum_mid = {1'b0, r_lsum} + 49'(r_len);
        lsum_end = {1'b0, r_lsum} + 49'(vl_c);
        st_c     = r_degen ? ST_DEGEN : ST_OK;
        mean_c   = (|calc_rsp.res[63:32]) ? SAT32 : calc_rsp.res[31:0];
    end

    always_comb begin
        calc_req.start = 1'b0;
        calc_req.op    = CALC_MUL;
        calc_req.a     = '0;
        calc_req.b     = '0;
        case (r_state)
            S_SQ: begin
                calc_req.start = !r_wait;
                calc_req.a     = 64'(r_a[r_i]);
                calc_req.b     = 64'(r_a[r_i]);
            end
            S_RT, S_KRT: begin
                calc_req.start = !r_wait;
                calc_req.op    = CALC_SQRT;
                calc_req.a     = r_sum;
            end
            S_TDIV: begin
                calc_req.start = !r_wait && (r_ls != '0);
                calc_req.op    = CALC_DIV;
                calc_req.a     = 64'({r_a[r_i], TAN_BITS'(0)});
                calc_req.b     = 64'(r_ls);
            end
            S_KSQ: begin
                calc_req.start = !r_wait;
                calc_req.a     = 64'(kmag[r_i]);
                calc_req.b     = 64'(kmag[r_i]);
            end
            S_KDIV: begin
                calc_req.start = !r_wait;
                calc_req.op    = CALC_DIV;
                calc_req.a     = 64'(r_ls) << (FRAC_BITS + 2);
                calc_req.b     = 64'(r_L) << 16;
            end
            S_KMUL0: begin
                calc_req.start = !r_wait;
                calc_req.a     = 64'(r_k);
                calc_req.b     = 64'(r_len[31:0]);
            end
            S_KMUL1: begin
                calc_req.start = !r_wait;
                calc_req.a     = 64'(r_k);
                calc_req.b     = 64'(r_len[34:32]);
            end
            S_MEAN: begin
                calc_req.start = !r_wait && (r_lsum != '0);
                calc_req.op    = CALC_DIV;
                calc_req.a     = r_wsum;
                calc_req.b     = 64'(r_lsum);
            end
            default: begin
                calc_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_closed <= 1'b0;
            r_count  <= '0;
            r_max    <= '0;
            r_wsum   <= '0;
            r_lsum   <= '0;
            r_degen  <= 1'b0;
            r_last_k <= '0;
        end else begin
            if (i_cfg_we) r_closed <= i_cfg_data;
            if (calc_req.start) r_wait <= 1'b1;
            if (r_wait && calc_rsp.done) r_wait <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_p[0] <= i_in.coord_x;
                        r_p[1] <= i_in.coord_y;
                        r_p[2] <= i_in.coord_z;
                        r_last <= i_in.last_point;
                        r_d[0] <= {i_in.coord_x[31], i_in.coord_x}
                                  - {r_prev_p[0][31], r_prev_p[0]};
                        r_d[1] <= {i_in.coord_y[31], i_in.coord_y}
                                  - {r_prev_p[1][31], r_prev_p[1]};
                        r_d[2] <= {i_in.coord_z[31], i_in.coord_z}
                                  - {r_prev_p[2][31], r_prev_p[2]};
                        r_mode <= M_SEG;
                        if (i_in.last_point && r_closed) r_state <= S_FIN;
                        else if (r_count != '0) r_state <= S_PREP;
                        else r_state <= S_UPD;
                    end
                end
                S_PREP: begin
                    r_a     <= a_c;
                    r_s     <= s_c;
                    r_sum   <= '0;
                    r_i     <= 2'd0;
                    r_state <= S_SQ;
                end
                S_SQ, S_KSQ: begin
                    if (r_wait && calc_rsp.done) begin
                        r_sum <= r_sum + calc_rsp.res;
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_state <= (r_state == S_SQ) ? S_RT : S_KRT;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_RT: begin
                    if (r_wait && calc_rsp.done) begin
                        r_ls <= calc_rsp.res[31:0];
                        case (r_mode)
                            M_SEG: begin
                                r_L     <= vl_c;
                                r_i     <= 2'd0;
                                r_state <= S_TDIV;
                            end
                            M_MID: begin
                                r_len   <= vl_c;
                                r_state <= S_KMUL0;
                            end
                            default: begin
                                r_lsum  <= lsum_end[48] ? '1 : lsum_end[47:0];
                                r_state <= S_MEAN;
                            end
                        endcase
                    end
                end
                S_TDIV: begin
                    if ((!r_wait && r_ls == '0) || (r_wait && calc_rsp.done)) begin
                        if (r_ls == '0) r_t[r_i] <= '0;
                        else if (r_d[r_i][32]) r_t[r_i] <= -$signed(calc_rsp.res[31:0]);
                        else r_t[r_i] <= $signed(calc_rsp.res[31:0]);
                        if (r_i == 2'd2) r_state <= S_SEG;
                        else r_i <= r_i + 2'd1;
                    end
                end
                S_SEG: begin
                    if (r_L == '0) r_degen <= 1'b1;
                    if (r_count == CW'(1)) begin
                        r_prev_m <= r_p;
                        r_state  <= S_UPD;
                    end else if (r_L == '0) begin
                        r_k     <= SAT32;
                        r_state <= S_MIDP;
                    end else begin
                        r_sum   <= '0;
                        r_i     <= 2'd0;
                        r_state <= S_KSQ;
                    end
                end
                S_KRT: begin
                    if (r_wait && calc_rsp.done) begin
                        r_ls    <= calc_rsp.res[31:0];
                        r_state <= S_KDIV;
                    end
                end
                S_KDIV: begin
                    if (r_wait && calc_rsp.done) begin
                        r_k     <= (|calc_rsp.res[63:32]) ? SAT32 : calc_rsp.res[31:0];
                        r_state <= S_MIDP;
                    end
                end
                S_MIDP: begin
                    r_mid <= mid_c;
                    for (int i = 0; i < 3; i++) begin
                        r_d[i] <= {mid_c[i][31], mid_c[i]} - {r_prev_m[i][31], r_prev_m[i]};
                    end
                    r_mode  <= M_MID;
                    r_state <= S_PREP;
                end
                S_KMUL0: begin
                    if (r_wait && calc_rsp.done) begin
                        r_prod  <= 67'(calc_rsp.res);
                        r_state <= S_KMUL1;
                    end
                end
                S_KMUL1: begin
                    if (r_wait && calc_rsp.done) begin
                        r_prod  <= r_prod + (67'(calc_rsp.res) << 32);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_k > r_max) r_max <= r_k;
                    r_wsum   <= wsum_add[64] ? '1 : wsum_add[63:0];
                    r_lsum   <= lsum_mid[48] ? '1 : lsum_mid[47:0];
                    r_last_k <= r_k;
                    r_prev_m <= r_mid;
                    if (r_count == CW'(2)) begin
                        r_out   <= mk_out('0, r_closed ? r_k : '0, 1'b0, '0, '0, st_c);
                        r_state <= S_EMA;
                    end else begin
                        r_out   <= mk_out(16'(r_count - CW'(1)), r_k, 1'b0, '0, '0, st_c);
                        r_state <= S_EMB;
                    end
                end
                S_EMA: begin
                    if (i_out_ready) begin
                        r_out   <= mk_out(16'(r_count - CW'(1)), r_k, 1'b0, '0, '0, st_c);
                        r_state <= S_EMB;
                    end
                end
                S_EMB: begin
                    if (i_out_ready) r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_count != '0) r_prev_t <= r_t;
                    r_prev_p <= r_p;
                    if (r_count != CW'(MAX_POINTS)) r_count <= r_count + CW'(1);
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    if (r_count < CW'(3)) begin
                        r_out   <= mk_out('0, '0, 1'b1, '0, '0, ST_FEW);
                        r_state <= S_EMF;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_d[i] <= {r_prev_p[i][31], r_prev_p[i]}
                                      - {r_prev_m[i][31], r_prev_m[i]};
                        end
                        r_mode  <= M_END;
                        r_state <= S_PREP;
                    end
                end
                S_MEAN: begin
                    if ((!r_wait && r_lsum == '0) || (r_wait && calc_rsp.done)) begin
                        r_out   <= mk_out(16'(r_count - CW'(1)),
                                          r_closed ? r_last_k : '0, 1'b1,
                                          (r_lsum == '0) ? '0 : mean_c, r_max, st_c);
                        r_state <= S_EMF;
                    end
                end
                S_EMF: begin
                    if (i_out_ready) begin
                        r_count  <= '0;
                        r_max    <= '0;
                        r_wsum   <= '0;
                        r_lsum   <= '0;
                        r_degen  <= 1'b0;
                        r_last_k <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMA) || (r_state == S_EMB) || (r_state == S_EMF);
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an input transfer");

    a_few_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_FEW) |->
        (o_out.run_end && o_out.curvature == '0 && o_out.mean_curvature == '0))
        else $error("short curve result malformed");

    a_calc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_req.start |-> !r_wait)
        else $error("arithmetic unit restarted while busy");
`endif

endmodule

[hdl/curv_calc.sv]
module curv_calc
    import curv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_calc_req i_req,
    output t_calc_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    t_calc_op    r_op;
    logic [63:0] r_acc;
    logic [64:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_den;
    logic [5:0]  r_cnt;
    logic [63:0] r_res;

    logic [64:0] trial;
    logic [64:0] sub;
    logic [65:0] diff;
    logic        ge;
    logic [63:0] q_next;

    // shared restoring step: one quotient or root bit per cycle
    always_comb begin
        if (r_op == CALC_SQRT) begin
            trial = {r_rem[62:0], r_acc[63:62]};
            sub   = {1'b0, r_q[61:0], 2'b01};
        end else begin
            trial = {r_rem[63:0], r_acc[63]};
            sub   = {1'b0, r_den};
        end
        diff   = {1'b0, trial} - {1'b0, sub};
        ge     = !diff[65];
        q_next = {r_q[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                if (i_req.op == CALC_MUL) begin
                    r_res  <= i_req.a[31:0] * i_req.b[31:0];
                    r_done <= 1'b1;
                end else begin
                    r_acc  <= i_req.a;
                    r_den  <= i_req.b;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_cnt  <= (i_req.op == CALC_DIV) ? 6'd63 : 6'd31;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[64:0] : trial;
                r_q   <= q_next;
                r_acc <= (r_op == CALC_SQRT) ? (r_acc << 2) : (r_acc << 1);
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= q_next;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

[dv/testbench.sv]
module testbench;
    import curv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXP = 65536;
    localparam int KAPPA_SHIFT = 16 + 2;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 600;
    localparam longint LIMIT = 3_000_000;
    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    curve_curvature_stream_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // curvature model state
    bit          closed_mode;
    longint      prev_pt [3];
    longint      prev_tan[3];
    longint      prev_mid[3];
    int          pts_seen;
    logic [31:0] peak_kappa;
    logic [63:0] weighted_acc;
    logic [63:0] length_acc;
    bit          degen_seen;
    logic [31:0] last_kappa;

    t_out_item   expected_results[$];
    int          error_count;
    int          points_sent;
    int          results_checked;
    int          curves_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_seq;
    int          hold_seen;
    int          hold_cnt;
    longint      cycle_count;

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] seg_len(input longint d[3], output longint t[3]);
        logic [63:0] a[3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] ls;
        int s;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) a[i] = d[i] < 0 ? -d[i] : d[i];
        m = a[0];
        if (a[1] > m) m = a[1];
        if (a[2] > m) m = a[2];
        while ((m >> s) >= (64'd1 << 31)) s++;
        for (int i = 0; i < 3; i++) begin
            a[i] = a[i] >> s;
            sum = sum + a[i] * a[i];
        end
        ls = root64(sum);
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = ls != 0 ? longint'((a[i] << TAN_BITS) / ls) : 0;
            t[i] = d[i] < 0 ? -q : q;
        end
        return ls << s;
    endfunction

    function automatic t_out_item make_result(int idx, logic [31:0] k, bit fin,
                                              logic [31:0] mn, logic [31:0] mx,
                                              t_status st);
        t_out_item r;
        r.point_index    = idx[15:0];
        r.curvature      = k;
        r.run_end        = fin;
        r.mean_curvature = mn;
        r.max_curvature  = mx;
        r.status         = st;
        return r;
    endfunction

    function automatic int clamp_index(int c);
        return c < MAXP ? c : MAXP - 1;
    endfunction

    function automatic void add_length(logic [63:0] len);
        length_acc = length_acc + len;
        if (length_acc > LEN_MAX) length_acc = LEN_MAX;
    endfunction

    function automatic void clear_curve();
        for (int i = 0; i < 3; i++) begin
            prev_pt[i] = 0;
            prev_tan[i] = 0;
            prev_mid[i] = 0;
        end
        pts_seen = 0;
        peak_kappa = 0;
        weighted_acc = 0;
        length_acc = 0;
        degen_seen = 0;
        last_kappa = 0;
    endfunction

    function automatic void predict_point(t_in_item it);
        longint      p[3];
        longint      d[3];
        longint      t[3];
        longint      tt[3];
        longint      mid[3];
        logic [63:0] seg;
        logic [63:0] kappa;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] mean;
        logic [127:0] prod;
        logic [64:0] acc;
        t_status     st;
        p[0] = longint'(it.coord_x);
        p[1] = longint'(it.coord_y);
        p[2] = longint'(it.coord_z);
        if (!(it.last_point && closed_mode)) begin
            if (pts_seen >= 1) begin
                for (int i = 0; i < 3; i++) d[i] = p[i] - prev_pt[i];
                seg = seg_len(d, t);
                if (seg == 0) degen_seen = 1;
                if (pts_seen == 1) begin
                    for (int i = 0; i < 3; i++) prev_mid[i] = p[i];
                end else begin
                    if (seg == 0) begin
                        kappa = SAT32;
                    end else begin
                        sq = 0;
                        for (int i = 0; i < 3; i++) begin
                            longint df;
                            df = t[i] - prev_tan[i];
                            if (df < 0) df = -df;
                            sq = sq + df * df;
                        end
                        kappa = (root64(sq) << KAPPA_SHIFT) / (seg << 16);
                        if (kappa > SAT32) kappa = SAT32;
                    end
                    for (int i = 0; i < 3; i++) begin
                        mid[i] = (p[i] + prev_pt[i]) >>> 1;
                        d[i] = mid[i] - prev_mid[i];
                    end
                    len = seg_len(d, tt);
                    if (kappa[31:0] > peak_kappa) peak_kappa = kappa[31:0];
                    prod = kappa * len;
                    acc = {1'b0, weighted_acc} +
                          {1'b0, (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0]};
                    weighted_acc = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
                    add_length(len);
                    st = degen_seen ? ST_DEGEN : ST_OK;
                    if (pts_seen == 2)
                        expected_results.push_back(make_result(0,
                            closed_mode ? kappa[31:0] : 32'd0, 0, 0, 0, st));
                    expected_results.push_back(make_result(clamp_index(pts_seen - 1),
                        kappa[31:0], 0, 0, 0, st));
                    last_kappa = kappa[31:0];
                    for (int i = 0; i < 3; i++) prev_mid[i] = mid[i];
                end
                for (int i = 0; i < 3; i++) prev_tan[i] = t[i];
            end
            for (int i = 0; i < 3; i++) prev_pt[i] = p[i];
            if (pts_seen < MAXP) pts_seen++;
        end
        if (it.last_point) begin
            if (pts_seen < 3) begin
                expected_results.push_back(make_result(0, 0, 1, 0, 0, ST_FEW));
            end else begin
                for (int i = 0; i < 3; i++) d[i] = prev_pt[i] - prev_mid[i];
                add_length(seg_len(d, tt));
                mean = length_acc != 0 ? weighted_acc / length_acc : 0;
                if (mean > SAT32) mean = SAT32;
                expected_results.push_back(make_result(clamp_index(pts_seen - 1),
                    closed_mode ? last_kappa : 32'd0, 1, mean[31:0], peak_kappa,
                    degen_seen ? ST_DEGEN : ST_OK));
            end
            clear_curve();
            curves_sent++;
        end
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
        t_in_item it;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.last_point = fin;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_point(it);
        points_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_closed(bit v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        closed_mode = v;
    endtask

    function automatic logic [31:0] q16(int v);
        return v << 16;
    endfunction

    task automatic test_open_basic();
        write_closed(0);
        send_point(q16(0), q16(0), q16(0), 0);
        send_point(q16(1), q16(0), q16(0), 0);
        send_point(q16(1), q16(1), q16(0), 0);
        send_point(q16(2), q16(1), q16(1), 1);
    endtask

    task automatic test_short_curves();
        send_point(q16(3), q16(4), q16(5), 1);
        send_point(q16(3), q16(4), q16(5), 0);
        send_point(q16(-3), q16(9), q16(1), 1);
    endtask

    task automatic test_zero_length();
        send_point(q16(1), q16(1), q16(1), 0);
        send_point(q16(1), q16(1), q16(1), 0);
        send_point(q16(2), q16(3), q16(1), 0);
        send_point(q16(2), q16(3), q16(1), 1);
    endtask

    task automatic test_extremes();
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 0);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
    endtask

    task automatic test_closed();
        write_closed(1);
        send_point(q16(0), q16(0), q16(0), 0);
        send_point(q16(2), q16(0), q16(0), 0);
        send_point(q16(2), q16(2), q16(0), 0);
        send_point(q16(0), q16(2), q16(0), 0);
        send_point(q16(0), q16(0), q16(0), 1);
        send_point(q16(5), q16(5), q16(5), 0);
        send_point(q16(6), q16(5), q16(5), 0);
        send_point(q16(5), q16(5), q16(5), 1);
    endtask

    task automatic send_random_curve();
        int n;
        int mode;
        logic [31:0] c[3];
        logic [31:0] first[3];
        n = $urandom_range(1, 8);
        mode = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) c[i] = $urandom;
        for (int k = 0; k < n; k++) begin
            bit fin;
            fin = (k == n - 1);
            if (mode < 80) begin
                for (int i = 0; i < 3; i++)
                    c[i] = (k == 0) ? 32'($signed($urandom_range(0, 32'h01FF_FFFF))
                                          - 32'sh0100_0000)
                                    : c[i] + 32'($signed($urandom_range(0, 32'h001F_FFFF))
                                          - 32'sh0010_0000);
            end else if (mode < 90) begin
                for (int i = 0; i < 3; i++) c[i] = $urandom;
            end else if ($urandom_range(0, 1) == 0) begin
                for (int i = 0; i < 3; i++) c[i] = c[i] + $urandom_range(0, 3) - 1;
            end
            if (k == 0) first = c;
            if (fin && closed_mode && $urandom_range(0, 9) != 0)
                send_point(first[0], first[1], first[2], 1);
            else
                send_point(c[0], c[1], c[2], fin);
        end
    endtask

    task automatic test_random_phase(int s_pct, int r_pct);
        int goal;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_closed(0);
        goal = points_sent + 50;
        while (points_sent < goal) send_random_curve();
        write_closed(1);
        goal = points_sent + 50;
        while (points_sent < goal) send_random_curve();
    endtask

    task automatic test_backpressure();
        write_closed(0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq++;
        for (int k = 0; k < 6; k++)
            send_point(q16(k), q16(k * k), q16(-k), k == 5);
    endtask

    // result checker and receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt <= 0;
            hold_seen <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result, point_index %0d", o_out.point_index);
                    error_count++;
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    results_checked++;
                    if (o_out.point_index !== e.point_index) begin
                        $error("point_index exp %0d got %0d", e.point_index, o_out.point_index);
                        error_count++;
                    end
                    if (o_out.curvature !== e.curvature) begin
                        $error("curvature exp %h got %h", e.curvature, o_out.curvature);
                        error_count++;
                    end
                    if (o_out.run_end !== e.run_end) begin
                        $error("run_end exp %0d got %0d", e.run_end, o_out.run_end);
                        error_count++;
                    end
                    if (o_out.mean_curvature !== e.mean_curvature) begin
                        $error("mean_curvature exp %h got %h", e.mean_curvature,
                               o_out.mean_curvature);
                        error_count++;
                    end
                    if (o_out.max_curvature !== e.max_curvature) begin
                        $error("max_curvature exp %h got %h", e.max_curvature,
                               o_out.max_curvature);
                        error_count++;
                    end
                    if (o_out.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_out.status);
                        error_count++;
                    end
                end
            end
            if (hold_seen != hold_seq) begin
                hold_seen <= hold_seq;
                hold_cnt <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        closed_mode = 0;
        clear_curve();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_open_basic();
        test_short_curves();
        test_zero_length();
        test_extremes();
        test_closed();
        test_backpressure();
        test_random_phase(37, 49);
        test_random_phase(49, 37);
        test_random_phase(0, 0);
        drain();
        $display("%0d points in %0d curves, %0d results checked", points_sent, curves_sent,
                 results_checked);
        $display("open and closed curves, short and degenerate curves, extremes, stalls");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
